[hw/rtl/i2c_ets_pkg.sv]
// Shared types and constants for the I2C EEPROM transaction sequencer.
// No dependencies; every module of the block imports this package.
package i2c_ets_pkg;

  // Defaults for the top-level parameters
  localparam int COUNT_WIDTH_DEF = 16;  // byte counter width, 8..32
  localparam int QUEUE_DEPTH_DEF = 2;   // front/back queue depth, 2 or more

  localparam logic [3:0] DEV_TYPE_RESET = 4'hA;
  localparam logic [3:0] STATUS_OK      = 4'h0;
  localparam logic       RW_WRITE       = 1'b0;
  localparam logic       RW_READ        = 1'b1;

  // Transaction kinds as carried in op_kind
  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_POLL  = 2'd2;

  // tuser of the input stream
  localparam logic REQ_NEW  = 1'b0;
  localparam logic REQ_DONE = 1'b1;

  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_START    = 4'd1,
    PH_CTRL     = 4'd2,
    PH_ADDR_HI  = 4'd3,
    PH_ADDR_LO  = 4'd4,
    PH_RESTART  = 4'd5,
    PH_RD_CTRL  = 4'd6,
    PH_READ     = 4'd7,
    PH_ACK      = 4'd8,
    PH_NAK      = 4'd9,
    PH_DATA     = 4'd10,
    PH_STOP     = 4'd11
  } phase_e;

  typedef enum logic [2:0] {
    CMD_NONE    = 3'd0,
    CMD_START   = 3'd1,
    CMD_RESTART = 3'd2,
    CMD_WRITE   = 3'd3,
    CMD_READ    = 3'd4,
    CMD_ACK     = 3'd5,
    CMD_NAK     = 3'd6,
    CMD_STOP    = 3'd7
  } cmd_e;

  // Item class decided by the front
  typedef enum logic [1:0] {
    KIND_REQ = 2'd0,  // valid transaction request
    KIND_CPL = 2'd1,  // primitive completion
    KIND_NOP = 2'd2   // request with an unknown op kind
  } item_kind_e;

  // Input tdata layout, lowest field last
  typedef struct packed {
    logic [5:0]  pad;
    logic [7:0]  tx_byte;
    logic [7:0]  rx_byte;
    logic [3:0]  prim_status;
    logic [15:0] byte_count;
    logic        short_addr;
    logic [15:0] mem_addr;
    logic [2:0]  chip_select;
    logic [1:0]  op_kind;
  } in_data_t;

  // Output tdata layout, lowest field last
  typedef struct packed {
    logic [0:0]  pad;
    logic [3:0]  txn_status;
    logic [7:0]  read_data;
    logic [7:0]  prim_byte;
    logic [2:0]  prim_cmd;
  } out_data_t;

  // Entry of the queue between front and back
  typedef struct packed {
    item_kind_e  kind;
    logic [1:0]  op_kind;
    logic [2:0]  chip_select;
    logic [15:0] mem_addr;
    logic        short_addr;
    logic [15:0] byte_count;
    logic [3:0]  prim_status;
    logic [7:0]  rx_byte;
    logic [7:0]  tx_byte;
  } item_t;

  // Queue status toward the front and back
  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

endpackage

[hw/rtl/i2c_ets_front.sv]
// Front of the sequencer: accepts stream items, classifies them, pushes them.
// Depends on i2c_ets_pkg.
module i2c_ets_front import i2c_ets_pkg::*; (
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  in_data_t    s_axis_tdata,
  input  logic        s_axis_tuser,
  input  queue_stat_t qstat_i,
  output logic        push_o,
  output item_t       push_item_o
);

  assign s_axis_tready = !qstat_i.full;
  assign push_o        = s_axis_tvalid && !qstat_i.full;

  always_comb begin
    push_item_o.op_kind     = s_axis_tdata.op_kind;
    push_item_o.chip_select = s_axis_tdata.chip_select;
    push_item_o.mem_addr    = s_axis_tdata.mem_addr;
    push_item_o.short_addr  = s_axis_tdata.short_addr;
    push_item_o.byte_count  = s_axis_tdata.byte_count;
    push_item_o.prim_status = s_axis_tdata.prim_status;
    push_item_o.rx_byte     = s_axis_tdata.rx_byte;
    push_item_o.tx_byte     = s_axis_tdata.tx_byte;
    // Drop unknown op kinds here so the back sees a plain no-op
    if (s_axis_tuser == REQ_DONE) begin
      push_item_o.kind = KIND_CPL;
    end else if (s_axis_tdata.op_kind == OP_READ || s_axis_tdata.op_kind == OP_WRITE ||
                 s_axis_tdata.op_kind == OP_POLL) begin
      push_item_o.kind = KIND_REQ;
    end else begin
      push_item_o.kind = KIND_NOP;
    end
  end

endmodule

[hw/rtl/i2c_ets_queue.sv]
// Short register queue between the front and back of the sequencer.
// Depends on i2c_ets_pkg for the entry type.
module i2c_ets_queue import i2c_ets_pkg::*; #(
  parameter int Depth = QUEUE_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  item_t       push_item_i,
  input  logic        pop_i,
  output item_t       head_o,
  output queue_stat_t qstat_o
);

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  item_t           mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign qstat_o.full  = (cnt_q == FullCnt);
  assign qstat_o.empty = (cnt_q == '0);
  assign head_o        = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

[hw/rtl/i2c_ets_back.sv]
// Back of the sequencer: transaction state machine and output register.
// Depends on i2c_ets_pkg.
module i2c_ets_back import i2c_ets_pkg::*; #(
  parameter int CountWidth = COUNT_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [3:0]  dev_type_i,
  input  item_t       head_i,
  input  queue_stat_t qstat_i,
  output logic        pop_o,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output out_data_t   m_axis_tdata,
  output logic        m_axis_tuser,
  output logic        m_axis_tlast
);

  phase_e                phase_q, phase_d;
  logic [1:0]            kind_q, kind_d;
  logic [2:0]            sel_q, sel_d;
  logic [15:0]           addr_q, addr_d;
  logic                  short_q, short_d;
  logic [CountWidth-1:0] total_q, total_d;
  logic [CountWidth-1:0] done_q, done_d;

  logic                  out_valid_q, out_valid_d;
  out_data_t             out_data_q, out_data_d;
  logic                  out_rvalid_q, out_rvalid_d;
  logic                  out_last_q, out_last_d;

  logic                  fail;
  logic                  is_cpl;
  logic [CountWidth-1:0] done_inc;
  logic                  more_now;
  logic                  more_inc;
  logic [7:0]            ctrl_wr;
  logic [7:0]            ctrl_rd;

  assign pop_o    = !qstat_i.empty && (!out_valid_q || m_axis_tready);
  assign fail     = (head_i.prim_status != STATUS_OK);
  assign is_cpl   = (head_i.kind == KIND_CPL);
  assign done_inc = done_q + 1'b1;
  assign more_now = (done_q < total_q);
  assign more_inc = (done_inc < total_q);
  assign ctrl_wr  = {dev_type_i, sel_q, RW_WRITE};
  assign ctrl_rd  = {dev_type_i, sel_q, RW_READ};

  // Next phase
  always_comb begin
    phase_d = phase_q;
    if (head_i.kind == KIND_REQ) begin
      phase_d = PH_START;
    end else if (is_cpl) begin
      unique case (phase_q)
        PH_IDLE:    phase_d = PH_IDLE;
        PH_START:   phase_d = fail ? PH_IDLE : PH_CTRL;
        PH_CTRL: begin
          if (fail)                 phase_d = PH_IDLE;
          else if (kind_q == OP_POLL) phase_d = PH_STOP;
          else if (short_q)         phase_d = PH_ADDR_LO;
          else                      phase_d = PH_ADDR_HI;
        end
        PH_ADDR_HI: phase_d = fail ? PH_IDLE : PH_ADDR_LO;
        PH_ADDR_LO: begin
          if (fail)                 phase_d = PH_IDLE;
          else if (kind_q == OP_READ) phase_d = PH_RESTART;
          else if (more_now)        phase_d = PH_DATA;
          else                      phase_d = PH_STOP;
        end
        PH_RESTART: phase_d = fail ? PH_IDLE : PH_RD_CTRL;
        PH_RD_CTRL: phase_d = fail ? PH_IDLE : (more_now ? PH_READ : PH_NAK);
        PH_READ:    phase_d = fail ? PH_IDLE : (more_inc ? PH_ACK : PH_NAK);
        PH_ACK:     phase_d = PH_READ;
        PH_NAK:     phase_d = PH_STOP;
        PH_DATA:    phase_d = fail ? PH_IDLE : (more_inc ? PH_DATA : PH_STOP);
        PH_STOP:    phase_d = PH_IDLE;
        default:    phase_d = PH_IDLE;
      endcase
    end
  end

  // Result of the item at the queue head
  always_comb begin
    out_data_d   = '0;
    out_rvalid_d = 1'b0;
    out_last_d   = 1'b0;
    if (head_i.kind == KIND_REQ) begin
      out_data_d.prim_cmd = CMD_START;
    end else if (is_cpl) begin
      if (fail && (phase_q == PH_START || phase_q == PH_CTRL || phase_q == PH_ADDR_HI ||
                   phase_q == PH_ADDR_LO || phase_q == PH_RESTART ||
                   phase_q == PH_RD_CTRL || phase_q == PH_READ || phase_q == PH_DATA)) begin
        // Abort without a stop and pass the failing status on
        out_last_d            = 1'b1;
        out_data_d.txn_status = head_i.prim_status;
      end else begin
        unique case (phase_q)
          PH_START: begin
            out_data_d.prim_cmd  = CMD_WRITE;
            out_data_d.prim_byte = ctrl_wr;
          end
          PH_CTRL: begin
            if (kind_q == OP_POLL) begin
              out_data_d.prim_cmd = CMD_STOP;
            end else begin
              out_data_d.prim_cmd  = CMD_WRITE;
              out_data_d.prim_byte = short_q ? addr_q[7:0] : addr_q[15:8];
            end
          end
          PH_ADDR_HI: begin
            out_data_d.prim_cmd  = CMD_WRITE;
            out_data_d.prim_byte = addr_q[7:0];
          end
          PH_ADDR_LO: begin
            if (kind_q == OP_READ) begin
              out_data_d.prim_cmd = CMD_RESTART;
            end else if (more_now) begin
              out_data_d.prim_cmd  = CMD_WRITE;
              out_data_d.prim_byte = head_i.tx_byte;
            end else begin
              out_data_d.prim_cmd = CMD_STOP;
            end
          end
          PH_RESTART: begin
            out_data_d.prim_cmd  = CMD_WRITE;
            out_data_d.prim_byte = ctrl_rd;
          end
          PH_RD_CTRL: out_data_d.prim_cmd = more_now ? CMD_READ : CMD_NAK;
          PH_READ: begin
            out_data_d.prim_cmd  = more_inc ? CMD_ACK : CMD_NAK;
            out_data_d.read_data = head_i.rx_byte;
            out_rvalid_d         = 1'b1;
          end
          PH_ACK:  out_data_d.prim_cmd = CMD_READ;
          PH_NAK:  out_data_d.prim_cmd = CMD_STOP;
          PH_DATA: begin
            if (more_inc) begin
              out_data_d.prim_cmd  = CMD_WRITE;
              out_data_d.prim_byte = head_i.tx_byte;
            end else begin
              out_data_d.prim_cmd = CMD_STOP;
            end
          end
          PH_STOP: out_last_d = 1'b1;  // stop status is ignored
          default: out_data_d = '0;
        endcase
      end
    end
  end

  // Transaction context and byte counter
  always_comb begin
    kind_d  = kind_q;
    sel_d   = sel_q;
    addr_d  = addr_q;
    short_d = short_q;
    total_d = total_q;
    done_d  = done_q;
    if (head_i.kind == KIND_REQ) begin
      kind_d  = head_i.op_kind;
      sel_d   = head_i.chip_select;
      addr_d  = head_i.mem_addr;
      short_d = head_i.short_addr;
      total_d = CountWidth'(head_i.byte_count);
      done_d  = '0;
    end else if (is_cpl && !fail && (phase_q == PH_READ || phase_q == PH_DATA)) begin
      done_d = done_inc;
    end
  end

  assign out_valid_d = pop_o || (out_valid_q && !m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      kind_q      <= '0;
      sel_q       <= '0;
      addr_q      <= '0;
      short_q     <= 1'b0;
      total_q     <= '0;
      done_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (pop_o) begin
        phase_q <= phase_d;
        kind_q  <= kind_d;
        sel_q   <= sel_d;
        addr_q  <= addr_d;
        short_q <= short_d;
        total_q <= total_d;
        done_q  <= done_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_data_q   <= out_data_d;
      out_rvalid_q <= out_rvalid_d;
      out_last_q   <= out_last_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_rvalid_q;
  assign m_axis_tlast  = out_last_q;

endmodule

[hw/rtl/i2c_eeprom_transaction_sequencer.sv]
// Serial EEPROM transaction sequencer over a byte-level I2C master engine.
// Each accepted item is written to the queue; its result is then registered in the back output register.
// Throughput: one item per cycle while m_axis_tready holds; the back state machine updates once per item.
// Reset (rst_ni low, asynchronous): idle phase, empty queue, no result pending,
// device type code back to 0xA. Depends on i2c_ets_pkg and the front, queue, back.
module i2c_eeprom_transaction_sequencer import i2c_ets_pkg::*; #(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,  // byte counter width, 8..32
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF   // items buffered between front and back
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration: device type code, upper nibble of the control byte
  input  logic        cfg_we_i,
  input  logic [3:0]  cfg_wdata_i,
  // Input items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata from bit 0: op_kind[1:0], chip_select[4:2], mem_addr[20:5],
  // short_addr[21], byte_count[37:22], prim_status[41:38], rx_byte[49:42],
  // tx_byte[57:50], zero pad[63:58]
  input  logic [63:0] s_axis_tdata,
  // tuser: req_type (0 new request, 1 primitive completion)
  input  logic        s_axis_tuser,
  // Result items
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata from bit 0: prim_cmd[2:0], prim_byte[10:3], read_data[18:11],
  // txn_status[22:19], zero pad[23]
  output logic [23:0] m_axis_tdata,
  // tuser: read_valid
  output logic        m_axis_tuser,
  // tlast: txn_done, transaction finished or aborted on this item
  output logic        m_axis_tlast
);

  logic [3:0]  dev_type_q;
  logic        push;
  item_t       push_item;
  logic        pop;
  item_t       head;
  queue_stat_t qstat;
  out_data_t   out_data;

  // Configuration register; the user must write it only while the block is idle, the block does not enforce this
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_type_q <= DEV_TYPE_RESET;
    end else if (cfg_we_i) begin
      dev_type_q <= cfg_wdata_i;
    end
  end

  // Front: accept and classify items, drop unknown op kinds to a no-op
  i2c_ets_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (in_data_t'(s_axis_tdata)),
    .s_axis_tuser  (s_axis_tuser),
    .qstat_i       (qstat),
    .push_o        (push),
    .push_item_o   (push_item)
  );

  // Queue: lets the input keep flowing while a result waits downstream
  i2c_ets_queue #(
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .pop_i       (pop),
    .head_o      (head),
    .qstat_o     (qstat)
  );

  // Back: advance the transaction phase and register one result per item
  i2c_ets_back #(
    .CountWidth (COUNT_WIDTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .dev_type_i    (dev_type_q),
    .head_i        (head),
    .qstat_i       (qstat),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (out_data),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  assign m_axis_tdata = 24'(out_data);

endmodule

[tb/i2c_ets_sequence_check.sv]
// Result checker for the I2C EEPROM transaction sequencer testbench.
// Predicts each result item from the accepted input items and compares them in order.
// Depends on i2c_ets_pkg for field layouts, phases and primitive codes.
module i2c_ets_sequence_check import i2c_ets_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [3:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  // tdata from bit 0: op_kind, chip_select, mem_addr, short_addr, byte_count,
  // prim_status, rx_byte, tx_byte, zero pad
  input  logic [63:0] s_axis_tdata,
  // tuser: req_type
  input  logic        s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata from bit 0: prim_cmd, prim_byte, read_data, txn_status, zero pad
  input  logic [23:0] m_axis_tdata,
  // tuser: read_valid
  input  logic        m_axis_tuser,
  // tlast: txn_done
  input  logic        m_axis_tlast,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    cmd_e       cmd;
    logic [7:0] prim_byte;
    logic [7:0] read_data;
    logic       read_valid;
    logic       txn_done;
    logic [3:0] txn_status;
  } prim_result_t;

  // Predicted sequencer state
  logic [3:0]                 dev_type;
  phase_e                     phase;
  logic [1:0]                 txn_kind;
  logic [2:0]                 saved_select;
  logic [15:0]                saved_addr;
  logic                       saved_short;
  logic [COUNT_WIDTH_DEF-1:0] total_bytes;
  logic [COUNT_WIDTH_DEF-1:0] bytes_done;

  prim_result_t expected_prims[$];
  prim_result_t want;
  prim_result_t got;
  out_data_t    beat;

  function automatic string describe(input prim_result_t p);
    return $sformatf("cmd=%0d byte=%h data=%h rvalid=%b done=%b status=%0d",
                     p.cmd, p.prim_byte, p.read_data, p.read_valid, p.txn_done,
                     p.txn_status);
  endfunction

  // Advance the predicted sequencer by one item and return the primitive it issues.
  function automatic prim_result_t step_sequencer(input logic req, input in_data_t item);
    prim_result_t r;
    logic         fail;
    r    = '0;
    fail = (item.prim_status != STATUS_OK);
    if (req == REQ_NEW) begin
      if (item.op_kind > OP_POLL) return r;
      txn_kind     = item.op_kind;
      saved_select = item.chip_select;
      saved_addr   = item.mem_addr;
      saved_short  = item.short_addr;
      total_bytes  = item.byte_count;
      bytes_done   = '0;
      r.cmd        = CMD_START;
      phase        = PH_START;
      return r;
    end
    // ACK, NAK and stop results never abort; a completion while idle does nothing
    if (fail && phase != PH_IDLE && phase != PH_ACK && phase != PH_NAK && phase != PH_STOP) begin
      r.txn_done   = 1'b1;
      r.txn_status = item.prim_status;
      phase        = PH_IDLE;
      return r;
    end
    case (phase)
      PH_START: begin
        r.cmd       = CMD_WRITE;
        r.prim_byte = {dev_type, saved_select, RW_WRITE};
        phase       = PH_CTRL;
      end
      PH_CTRL: begin
        if (txn_kind == OP_POLL) begin
          r.cmd = CMD_STOP;
          phase = PH_STOP;
        end else if (saved_short) begin
          r.cmd       = CMD_WRITE;
          r.prim_byte = saved_addr[7:0];
          phase       = PH_ADDR_LO;
        end else begin
          r.cmd       = CMD_WRITE;
          r.prim_byte = saved_addr[15:8];
          phase       = PH_ADDR_HI;
        end
      end
      PH_ADDR_HI: begin
        r.cmd       = CMD_WRITE;
        r.prim_byte = saved_addr[7:0];
        phase       = PH_ADDR_LO;
      end
      PH_ADDR_LO: begin
        if (txn_kind == OP_READ) begin
          r.cmd = CMD_RESTART;
          phase = PH_RESTART;
        end else if (bytes_done < total_bytes) begin
          r.cmd       = CMD_WRITE;
          r.prim_byte = item.tx_byte;
          phase       = PH_DATA;
        end else begin
          r.cmd = CMD_STOP;
          phase = PH_STOP;
        end
      end
      PH_RESTART: begin
        r.cmd       = CMD_WRITE;
        r.prim_byte = {dev_type, saved_select, RW_READ};
        phase       = PH_RD_CTRL;
      end
      PH_RD_CTRL: begin
        if (bytes_done < total_bytes) begin
          r.cmd = CMD_READ;
          phase = PH_READ;
        end else begin
          r.cmd = CMD_NAK;
          phase = PH_NAK;
        end
      end
      PH_READ: begin
        r.read_data  = item.rx_byte;
        r.read_valid = 1'b1;
        bytes_done   = bytes_done + 1'b1;
        if (bytes_done < total_bytes) begin
          r.cmd = CMD_ACK;
          phase = PH_ACK;
        end else begin
          r.cmd = CMD_NAK;
          phase = PH_NAK;
        end
      end
      PH_ACK: begin
        r.cmd = CMD_READ;
        phase = PH_READ;
      end
      PH_NAK: begin
        r.cmd = CMD_STOP;
        phase = PH_STOP;
      end
      PH_DATA: begin
        bytes_done = bytes_done + 1'b1;
        if (bytes_done < total_bytes) begin
          r.cmd       = CMD_WRITE;
          r.prim_byte = item.tx_byte;
        end else begin
          r.cmd = CMD_STOP;
          phase = PH_STOP;
        end
      end
      PH_STOP: begin
        r.txn_done = 1'b1;
        phase      = PH_IDLE;
      end
      default: phase = PH_IDLE;
    endcase
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_type     = DEV_TYPE_RESET;
      phase        = PH_IDLE;
      txn_kind     = '0;
      saved_select = '0;
      saved_addr   = '0;
      saved_short  = 1'b0;
      total_bytes  = '0;
      bytes_done   = '0;
      expected_prims.delete();
      fail_count   = 0;
      pending <= 0;
    end else begin
      if (cfg_we_i) dev_type = cfg_wdata_i;
      // Compare results before queueing new predictions
      if (m_axis_tvalid && m_axis_tready) begin
        beat           = m_axis_tdata;
        got.cmd        = cmd_e'(beat.prim_cmd);
        got.prim_byte  = beat.prim_byte;
        got.read_data  = beat.read_data;
        got.read_valid = m_axis_tuser;
        got.txn_done   = m_axis_tlast;
        got.txn_status = beat.txn_status;
        if (expected_prims.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result item, expected none, actual %s",
                   $time, describe(got));
        end else begin
          want = expected_prims.pop_front();
          if (got !== want) begin
            fail_count++;
            $display("%0t: result mismatch, expected %s, actual %s",
                     $time, describe(want), describe(got));
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_prims.push_back(step_sequencer(s_axis_tuser, s_axis_tdata));
      pending <= expected_prims.size();
    end
  end

endmodule

[tb/tb.sv]
// Top of the I2C EEPROM transaction sequencer testbench: clock, reset and stimulus.
// Depends on i2c_ets_pkg, the sequencer RTL and i2c_ets_sequence_check.
module tb;
  import i2c_ets_pkg::*;

  // Op kind with no transaction behind it; the block must ignore such a request
  localparam logic [1:0] OP_UNKNOWN   = 2'd3;
  localparam logic [3:0] ST_NAK       = 4'd6;
  localparam logic [3:0] ST_OVERRUN   = 4'd8;
  localparam logic [3:0] ST_UNDEFINED = 4'hF;
  localparam int         STALL_LIMIT  = 2000;
  localparam int         PHASE_ITEMS  = 515;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [3:0]  cfg_wdata_i   = 4'h0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata  = '0;  // op_kind, chip_select, mem_addr, ... tx_byte from bit 0
  logic        s_axis_tuser  = 1'b0;  // req_type
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;  // prim_cmd, prim_byte, read_data, txn_status from bit 0
  logic        m_axis_tuser;  // read_valid
  logic        m_axis_tlast;  // txn_done

  int tx_idle_pct  = 33;
  int rx_idle_pct  = 48;
  int items_sent   = 0;
  int stall_cycles = 0;
  int fail_count;
  int pending;

  always #5 clk_i = ~clk_i;

  i2c_eeprom_transaction_sequencer DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  i2c_ets_sequence_check u_sequence_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .fail_count    (fail_count),
    .pending       (pending)
  );

  // Stall the result side at random, as the current idle rate says
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Count cycles without any item moving on either side; give up at the limit
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic logic [63:0] pack_item(input logic [1:0] op, input logic [2:0] chip,
                                            input logic [15:0] addr, input logic lo_only,
                                            input logic [15:0] count, input logic [3:0] status,
                                            input logic [7:0] rx, input logic [7:0] tx);
    in_data_t d;
    d.pad         = '0;
    d.op_kind     = op;
    d.chip_select = chip;
    d.mem_addr    = addr;
    d.short_addr  = lo_only;
    d.byte_count  = count;
    d.prim_status = status;
    d.rx_byte     = rx;
    d.tx_byte     = tx;
    return d;
  endfunction

  // Completions a clean transaction takes from start to the stop result
  function automatic int txn_length(input logic [1:0] op, input logic lo_only, input int count);
    int hi_byte;
    hi_byte = lo_only ? 0 : 1;
    if (op == OP_POLL) return 3;
    if (op == OP_WRITE) return 4 + hi_byte + count;
    if (count == 0) return 7 + hi_byte;
    return 6 + hi_byte + 2 * count;
  endfunction

  // Offer one item, idling first at random, and hold it until the block takes it
  task automatic send_item(input logic req, input logic [63:0] data);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= req;
    s_axis_tdata  <= data;
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
  endtask

  // Hold off the sender until every predicted result has come out
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic write_device_type(input logic [3:0] code);
    wait_drained();
    cfg_wdata_i <= code;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Send a request, then play the bus engine for n_cpl completions. The completion
  // at bad_idx carries bad_status; the other fields of each completion are junk.
  task automatic run_txn(input logic [1:0] op, input logic [2:0] chip, input logic [15:0] addr,
                         input logic lo_only, input logic [15:0] count, input int n_cpl,
                         input int bad_idx, input logic [3:0] bad_status);
    int k;
    send_item(REQ_NEW, pack_item(op, chip, addr, lo_only, count, 4'($urandom_range(15)),
                                 8'($urandom), 8'($urandom)));
    for (k = 0; k < n_cpl; k++) begin
      send_item(REQ_DONE, pack_item(2'($urandom_range(3)), 3'($urandom_range(7)),
                                    16'($urandom), 1'($urandom_range(1)), 16'($urandom),
                                    (k == bad_idx) ? bad_status : STATUS_OK,
                                    8'($urandom), 8'($urandom)));
    end
  endtask

  // Mostly well-formed transactions with random content; the rest are stray items,
  // aborts and transactions cut short by the next request.
  task automatic random_traffic(input int n_items);
    int          stop_at;
    int          n_cpl;
    int          bad_idx;
    logic [1:0]  op;
    logic        lo_only;
    logic [15:0] count;
    logic [3:0]  bad_status;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      if ($urandom_range(99) < 8) begin
        send_item(1'($urandom_range(1)),
                  pack_item(2'($urandom_range(3)), 3'($urandom_range(7)), 16'($urandom),
                            1'($urandom_range(1)), 16'($urandom),
                            4'($urandom_range(15)), 8'($urandom), 8'($urandom)));
      end else begin
        op      = 2'($urandom_range(2));
        lo_only = 1'($urandom_range(1));
        count   = ($urandom_range(99) < 85) ? 16'($urandom_range(5)) : 16'($urandom);
        // Large counts only run a few steps before the next request drops them
        n_cpl   = (count > 5) ? $urandom_range(8) : txn_length(op, lo_only, int'(count));
        bad_idx    = -1;
        bad_status = STATUS_OK;
        if (n_cpl > 0 && $urandom_range(99) < 20) begin
          bad_idx    = $urandom_range(n_cpl - 1);
          bad_status = 4'($urandom_range(15, 1));
          if ($urandom_range(1) == 0) n_cpl = bad_idx + 1;
        end
        run_txn(op, 3'($urandom_range(7)), 16'($urandom), lo_only, count, n_cpl, bad_idx,
                bad_status);
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Completion with nothing running: ignore it
    send_item(REQ_DONE, pack_item(OP_READ, 3'd0, 16'h0000, 1'b0, 16'h0000, STATUS_OK,
                                  8'h00, 8'h00));
    // Request with an unknown op kind: ignore it
    send_item(REQ_NEW, pack_item(OP_UNKNOWN, 3'd7, 16'hFFFF, 1'b1, 16'hFFFF, ST_UNDEFINED,
                                 8'hFF, 8'hFF));
    // Full-size write up to its first data byte, then dropped by the next request
    run_txn(OP_WRITE, 3'd7, 16'hFFFF, 1'b0, 16'hFFFF, 4, -1, STATUS_OK);
    // Zero-count read: NAK right after the read control word; stop status is ignored
    run_txn(OP_READ, 3'd0, 16'h0000, 1'b1, 16'h0000, 7, 6, ST_OVERRUN);
    // Poll aborted by a NAK on the control word
    run_txn(OP_POLL, 3'd5, 16'h5AA5, 1'b0, 16'h0000, 2, 1, ST_NAK);
    // Read aborted on the data byte by a status code outside the known set
    run_txn(OP_READ, 3'd2, 16'h8001, 1'b1, 16'd1, 6, 5, ST_UNDEFINED);

    write_device_type(4'h0);
    random_traffic(PHASE_ITEMS);

    // Swap the idle rates of the two sides
    tx_idle_pct = 48;
    rx_idle_pct = 33;
    write_device_type(4'hF);
    random_traffic(PHASE_ITEMS);

    // Full rate on both sides
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_device_type(4'($urandom_range(15)));
    random_traffic(PHASE_ITEMS);

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
